// ----- rtl/gtw_pkg.sv -----
package gtw_pkg;

	localparam int MAX_EDGES = 8;
	localparam int NODE_BITS = 4;

	localparam logic [3:0] NODE_MASK = 4'((1 << NODE_BITS) - 1);

	// APB map: register i at byte address 8*i
	localparam int PADDR_W      = 4;
	localparam int REG_SEL_BIT  = 3;
	localparam logic REG_EDGES  = 1'b0;
	localparam logic REG_COUNT  = 1'b1;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_MOVE  = 1'b1;

	localparam logic [1:0] ST_STARTED = 2'd0;
	localparam logic [1:0] ST_MOVED   = 2'd1;
	localparam logic [1:0] ST_NO_CONN = 2'd2;
	localparam logic [1:0] ST_STUCK   = 2'd3;

	typedef struct packed {
		logic load_in;
		logic scan;
		logic commit;
	} gtw_cmd_t;

	typedef struct packed {
		logic        wr_edges;
		logic        wr_count;
		logic [63:0] wdata;
	} gtw_cfg_t;

	function automatic logic node_eq(input logic [3:0] a, input logic [3:0] b);
		return a[NODE_BITS-1:0] == b[NODE_BITS-1:0];
	endfunction

	// Unused live edges touching node at
	function automatic logic [7:0] cand_mask(input logic [63:0] ends,
		input logic [3:0] cnt, input logic [7:0] used, input logic [3:0] at);
		logic [7:0] m;
		logic [3:0] ea;
		logic [3:0] eb;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			ea = ends[8*i +: 4];
			eb = ends[8*i+4 +: 4];
			if (i < MAX_EDGES && 4'(i) < cnt && !used[i] &&
			    (node_eq(ea, at) || node_eq(eb, at))) begin
				m[i] = 1'b1;
			end
		end
		return m;
	endfunction

	function automatic logic [2:0] first_idx(input logic [7:0] m);
		logic [2:0] idx;
		idx = '0;
		for (int i = 7; i >= 0; i--) begin
			if (m[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

	function automatic logic [3:0] pop8(input logic [7:0] m);
		logic [3:0] c;
		c = '0;
		for (int i = 0; i < 8; i++) begin
			c = c + 4'(m[i]);
		end
		return c;
	endfunction

endpackage

// ----- rtl/graph_trail_walker.sv -----
// A request is registered when accepted, then scanned and committed; commit
//   waits while a stalled result still holds the output register. The scan
//   of the eight-entry edge table needs the node left by the last commit.
// The next request is taken in the commit cycle, while the result waits downstream.
// Reset (arst_n low, asynchronous): edge table, edge count, used marks, node and
//   trail length clear to zero; no result is pending.
module graph_trail_walker (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gtw_pkg::PADDR_W-1:0]  paddr,
	input  logic [63:0]                  pwdata,
	output logic [63:0]                  prdata,
	output logic                         pready,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         command,
	input  logic [3:0]                   node,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   status,
	output logic [2:0]                   edge_index,
	output logic [7:0]                   candidate_mask,
	output logic [3:0]                   candidate_count,
	output logic [3:0]                   trail_length
);
	import gtw_pkg::*;

	gtw_cmd_t    cmd;
	gtw_cfg_t    cfg;
	logic        wr_en;
	logic        reg_sel;
	logic [63:0] edges_rd;
	logic [3:0]  count_rd;

	// Decode on the register-select address bit only, so every address
	// lands on one of the two registers.
	assign pready  = 1'b1;
	assign reg_sel = paddr[REG_SEL_BIT];
	assign wr_en   = psel && penable && pwrite && pready;

	always_comb begin
		cfg.wdata    = pwdata;
		cfg.wr_edges = 1'b0;
		cfg.wr_count = 1'b0;
		unique case (reg_sel)
			REG_EDGES: cfg.wr_edges = wr_en;
			REG_COUNT: cfg.wr_count = wr_en;
			default:   cfg.wr_edges = 1'b0;
		endcase
	end

	// Read back the selected register
	always_comb begin
		unique case (reg_sel)
			REG_EDGES: prdata = edges_rd;
			REG_COUNT: prdata = {60'd0, count_rd};
			default:   prdata = '0;
		endcase
	end

	// Sequence: accept -> scan (candidates and matching edges) -> commit
	gtw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Hold the edge table, trail state and the result register
	gtw_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg),
		.command         (command),
		.node            (node),
		.edges_rd        (edges_rd),
		.count_rd        (count_rd),
		.status          (status),
		.edge_index      (edge_index),
		.candidate_mask  (candidate_mask),
		.candidate_count (candidate_count),
		.trail_length    (trail_length)
	);

endmodule

// ----- rtl/gtw_ctrl.sv -----
module gtw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output gtw_pkg::gtw_cmd_t cmd
);
	import gtw_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_n;
	logic       out_valid_q;
	logic       out_free;
	logic       in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == S_IDLE) || (state_q == S_FINISH && out_free));
	assign in_take  = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		cmd.load_in = in_take;
		unique case (state_q)
			S_IDLE: begin
				if (in_take) state_n = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				state_n  = S_FINISH;
			end
			S_FINISH: begin
				// commit only when the output register can take the result
				if (out_free) begin
					cmd.commit = 1'b1;
					state_n    = in_take ? S_SCAN : S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_take_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_SCAN)
		else $error("accepted request not followed by scan");
	a_scan_finish: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |=> state_q == S_FINISH)
		else $error("scan not followed by finish");
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FINISH)
		else $error("result raised outside finish");
`endif

endmodule

// ----- rtl/gtw_dp.sv -----
module gtw_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  gtw_pkg::gtw_cmd_t cmd,
	input  gtw_pkg::gtw_cfg_t cfg,
	input  logic              command,
	input  logic [3:0]        node,
	output logic [63:0]       edges_rd,
	output logic [3:0]        count_rd,
	output logic [1:0]        status,
	output logic [2:0]        edge_index,
	output logic [7:0]        candidate_mask,
	output logic [3:0]        candidate_count,
	output logic [3:0]        trail_length
);
	import gtw_pkg::*;

	logic [63:0] edges_q;
	logic [3:0]  count_q;
	logic [7:0]  used_q;
	logic [3:0]  cur_q;
	logic [3:0]  trail_q;

	logic        cmd_q;
	logic [3:0]  node_q;
	logic [7:0]  cand_s1;
	logic [7:0]  match_s1;

	logic [1:0]  status_q;
	logic [2:0]  eidx_q;
	logic [7:0]  mask_q;
	logic [3:0]  mcount_q;

	logic [7:0]  cand_cur;
	logic [7:0]  match;
	logic        found;
	logic [2:0]  taken;
	logic [7:0]  used_n;
	logic [3:0]  cur_n;
	logic [3:0]  trail_n;
	logic [7:0]  new_mask;
	logic [1:0]  status_n;
	logic [2:0]  eidx_n;
	logic [7:0]  mask_n;

	assign edges_rd = edges_q;
	assign count_rd = count_q;

	// scan stage: candidates at the current node and edges reaching the target
	assign cand_cur = cand_mask(edges_q, count_q, used_q, cur_q);
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			match[i] = cand_cur[i] &&
				((node_eq(edges_q[8*i +: 4], node_q) && node_eq(edges_q[8*i+4 +: 4], cur_q)) ||
				 (node_eq(edges_q[8*i+4 +: 4], node_q) && node_eq(edges_q[8*i +: 4], cur_q)));
		end
	end

	assign found = |match_s1;
	assign taken = first_idx(match_s1);

	always_comb begin
		used_n   = used_q;
		cur_n    = cur_q;
		trail_n  = trail_q;
		status_n = ST_NO_CONN;
		eidx_n   = '0;
		if (cmd_q == CMD_START) begin
			used_n   = '0;
			cur_n    = node_q;
			trail_n  = '0;
			status_n = ST_STARTED;
		end else if (cand_s1 == '0) begin
			status_n = ST_STUCK;
		end else if (found) begin
			used_n   = used_q | (8'b1 << taken);
			cur_n    = node_q;
			trail_n  = trail_q + 4'd1;
			status_n = ST_MOVED;
			eidx_n   = taken;
		end
	end

	assign new_mask = cand_mask(edges_q, count_q, used_n, cur_n);

	always_comb begin
		case (status_n)
			ST_STUCK:   mask_n = '0;
			ST_NO_CONN: mask_n = cand_s1;
			default:    mask_n = new_mask;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_q <= '0;
			count_q <= '0;
			used_q  <= '0;
			cur_q   <= '0;
			trail_q <= '0;
		end else begin
			if (cfg.wr_edges) edges_q <= cfg.wdata;
			if (cfg.wr_count) count_q <= cfg.wdata[3:0];
			if (cmd.commit) begin
				used_q  <= used_n;
				cur_q   <= cur_n;
				trail_q <= trail_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q  <= command;
			node_q <= node & NODE_MASK;
		end
		if (cmd.scan) begin
			cand_s1  <= cand_cur;
			match_s1 <= match;
		end
		if (cmd.commit) begin
			status_q <= status_n;
			eidx_q   <= eidx_n;
			mask_q   <= mask_n;
			mcount_q <= pop8(mask_n);
		end
	end

	assign status          = status_q;
	assign edge_index      = eidx_q;
	assign candidate_mask  = mask_q;
	assign candidate_count = mcount_q;
	assign trail_length    = trail_q;

`ifndef SYNTHESIS
	a_trail_marks: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == 32'(trail_q))
		else $error("trail length disagrees with used marks");
	a_mask_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(mask_q & used_q) == 8'h00)
		else $error("reported candidate already used");
	a_fail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && status_n != ST_MOVED && status_n != ST_STARTED
		|=> cur_q == $past(cur_q) && used_q == $past(used_q))
		else $error("failed move changed the trail");
`endif

endmodule
